// ----- rtl/cpt_pkg.sv -----
// Shared types, codes and constants of the contact persistence table.
`timescale 1ns / 1ps

package cpt_pkg;

   // Field widths of the stream payloads and of a table entry.
   localparam int PARTNER_W = 16;
   localparam int POINT_W   = 32;
   localparam int AGE_W     = 20;

   // Default table depth and the cap on entries removed by one purge.
   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int MAX_RESULTS           = 16;

   // Register reset values.
   localparam logic [AGE_W-1:0] STALE_LIMIT_RESET = 20'd15000;
   localparam logic             EVENTS_EN_RESET   = 1'b1;

   // Register indexes of the configuration port.
   localparam logic CSR_STALE_LIMIT = 1'b0;
   localparam logic CSR_EVENTS_EN   = 1'b1;

   typedef enum logic [1:0] {
      ACT_REPORT = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_PURGE  = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      EV_BEGIN   = 2'd0,
      EV_PERSIST = 2'd1,
      EV_STOP    = 2'd2,
      EV_FULL    = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_FLUSH
   } state_type;

   // One stored contact.
   typedef struct packed {
      logic [AGE_W-1:0]            age;
      logic signed [POINT_W-1:0]   z;
      logic signed [POINT_W-1:0]   y;
      logic signed [POINT_W-1:0]   x;
      logic [PARTNER_W-1:0]        partner;
   } entry_type;

   // One result beat without its last flag.
   typedef struct packed {
      event_kind_type              kind;
      logic [PARTNER_W-1:0]        partner;
      logic signed [POINT_W-1:0]   x;
      logic signed [POINT_W-1:0]   y;
      logic signed [POINT_W-1:0]   z;
   } event_type;

   // Status that the entry unit hands back to the sequencer.
   typedef struct packed {
      logic             match;
      logic             stale;
      logic [AGE_W-1:0] aged;
   } alu_result_type;

endpackage

// ----- rtl/cpt_entry_ram.sv -----
// Entry memory of the contact table: one write port and one registered read port.
`timescale 1ns / 1ps

module cpt_entry_ram
   import cpt_pkg::*;
#(
   parameter int DEPTH = TABLE_ENTRIES_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cpt_entry_alu.sv -----
// Shared entry unit: partner compare, stale compare and saturating age add.
`timescale 1ns / 1ps

module cpt_entry_alu
   import cpt_pkg::*;
(
   input  entry_type            entry,
   input  logic [PARTNER_W-1:0] partner_id,
   input  logic [AGE_W-1:0]     delta_us,
   input  logic [AGE_W-1:0]     stale_limit_us,
   output alu_result_type       result
);

   logic [AGE_W:0] sum;

   // Age plus elapsed time, one bit wider to catch the overflow.
   assign sum = {1'b0, entry.age} + {1'b0, delta_us};

   always_comb begin
      result.match = (entry.partner == partner_id);
      result.stale = (entry.age > stale_limit_us);
      result.aged  = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];
   end

endmodule

// ----- rtl/contact_persistence_table.sv -----
// Top level of the contact persistence table: sequencer, command latch and result path.
`timescale 1ns / 1ps

// A command beat is accepted only while the block is idle. It then walks the stored
// entries one per cycle, while the result side does not stall it, through the single
// read port of the entry memory and the shared entry unit, then closes out, hands off
// the results and returns to idle. A purge or removal compacts the table during the
// same walk. Results of one command leave in order with rsp_tlast on the final beat; a
// time tick gives no result. The memory needs no clearing after reset: only entries
// below the count are ever used.
module contact_persistence_table
   import cpt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // Command stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata, from bit 0: partner_id[16], point_x[32], point_y[32], point_z[32],
   // delta_us[20], four zero bits.
   input  logic [135:0] req_tdata,
   // req_tuser: action[2].
   input  logic [1:0]   req_tuser,
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata, from bit 0: event_partner[16], event_x[32], event_y[32], event_z[32].
   output logic [111:0] rsp_tdata,
   // rsp_tuser: event_kind[2].
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   // Configuration writes.
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [19:0]  csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int REM_W = $clog2(MAX_RESULTS + 1);

   // Registers.
   state_type               state_ff, state_in;
   logic [AGE_W-1:0]        stale_limit_ff;
   logic                    events_en_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        wptr_ff, wptr_in;
   logic [REM_W-1:0]        removed_ff, removed_in;
   logic                    found_ff, found_in;
   action_type              action_ff;
   logic [PARTNER_W-1:0]    pid_ff;
   logic signed [POINT_W-1:0] px_ff, py_ff, pz_ff;
   logic [AGE_W-1:0]        delta_ff;
   logic                    pend_valid_ff, pend_valid_in;
   event_type               pend_event_ff, pend_event_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   event_type               rsp_event_ff, rsp_event_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Datapath signals.
   logic                    accept;
   logic                    out_free;
   logic                    ev_fire;
   event_type               ev_data;
   logic                    stall;
   logic                    kill;
   logic                    last_idx;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   entry_type               mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;
   entry_type               entry;
   entry_type               report_entry;
   alu_result_type          alu;

   cpt_entry_ram #(
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(entry)
   );

   cpt_entry_alu u_alu (
      .entry         (entry),
      .partner_id    (pid_ff),
      .delta_us      (delta_ff),
      .stale_limit_us(stale_limit_ff),
      .result        (alu)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_idx   = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // The reported contact as a fresh entry.
   always_comb begin
      report_entry.partner = pid_ff;
      report_entry.x       = px_ff;
      report_entry.y       = py_ff;
      report_entry.z       = pz_ff;
      report_entry.age     = '0;
   end

   // Event raised by the current step and the stall it may cause.
   always_comb begin
      ev_fire = 1'b0;
      ev_data = '0;
      kill    = 1'b0;
      if (state_ff == ST_SCAN) begin
         case (action_ff)
            ACT_REPORT: begin
               ev_fire         = !found_ff && alu.match && events_en_ff;
               ev_data.kind    = EV_PERSIST;
               ev_data.partner = pid_ff;
               ev_data.x       = px_ff;
               ev_data.y       = py_ff;
               ev_data.z       = pz_ff;
            end
            ACT_TICK: begin
               ev_fire = 1'b0;
            end
            ACT_PURGE: begin
               kill            = alu.stale && (removed_ff < REM_W'(MAX_RESULTS));
               ev_fire         = kill && events_en_ff;
               ev_data.kind    = EV_STOP;
               ev_data.partner = entry.partner;
            end
            ACT_REMOVE: begin
               kill            = !found_ff && alu.match;
               ev_fire         = kill && events_en_ff;
               ev_data.kind    = EV_STOP;
               ev_data.partner = entry.partner;
            end
         endcase
      end else if (state_ff == ST_FINISH && action_ff == ACT_REPORT && !found_ff) begin
         ev_data.partner = pid_ff;
         if (count_ff < CNT_W'(TABLE_ENTRIES)) begin
            ev_fire      = events_en_ff;
            ev_data.kind = EV_BEGIN;
            ev_data.x    = px_ff;
            ev_data.y    = py_ff;
            ev_data.z    = pz_ff;
         end else begin
            ev_fire      = 1'b1;
            ev_data.kind = EV_FULL;
         end
      end
      stall = ev_fire && pend_valid_ff && !out_free;
   end

   // Sequencer: next state, table updates and the result path.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wptr_in       = wptr_ff;
      removed_in    = removed_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_event_in = pend_event_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_event_in  = rsp_event_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = entry;
      mem_raddr     = '0;

      // A new event parks in the pending slot, pushing the older one out.
      if (ev_fire && !stall) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_event_in = pend_event_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_event_in = ev_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in     = '0;
               wptr_in    = '0;
               removed_in = '0;
               found_in   = 1'b0;
               state_in   = (count_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stall) begin
               mem_raddr = idx_ff;
            end else begin
               mem_raddr = idx_ff + IDX_W'(1);
               case (action_ff)
                  ACT_REPORT: begin
                     if (!found_ff && alu.match) begin
                        found_in  = 1'b1;
                        mem_we    = 1'b1;
                        mem_wdata = report_entry;
                     end
                  end
                  ACT_TICK: begin
                     mem_we        = 1'b1;
                     mem_wdata.age = alu.aged;
                  end
                  ACT_PURGE, ACT_REMOVE: begin
                     if (kill) begin
                        removed_in = removed_ff + REM_W'(1);
                        found_in   = 1'b1;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = wptr_ff[IDX_W-1:0];
                        wptr_in   = wptr_ff + CNT_W'(1);
                     end
                  end
               endcase
               if (last_idx) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!stall) begin
               state_in = ST_FLUSH;
               case (action_ff)
                  ACT_REPORT: begin
                     // A miss appends at the end when there is room.
                     if (!found_ff && count_ff < CNT_W'(TABLE_ENTRIES)) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[IDX_W-1:0];
                        mem_wdata = report_entry;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_TICK: begin
                     count_in = count_ff;
                  end
                  ACT_PURGE, ACT_REMOVE: begin
                     count_in = wptr_ff;
                  end
               endcase
            end
         end
         ST_FLUSH: begin
            // The event still pending is the final one of this command.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_event_in  = pend_event_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         stale_limit_ff <= STALE_LIMIT_RESET;
         events_en_ff   <= EVENTS_EN_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_STALE_LIMIT: stale_limit_ff <= csr_wdata[AGE_W-1:0];
               CSR_EVENTS_EN:   events_en_ff   <= csr_wdata[0];
               default:         events_en_ff   <= events_en_ff;
            endcase
         end
      end
   end

   // Walk counters, command latch and event payloads.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      wptr_ff       <= wptr_in;
      removed_ff    <= removed_in;
      found_ff      <= found_in;
      pend_event_ff <= pend_event_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_last_ff   <= rsp_last_in;
      if (accept) begin
         action_ff <= action_type'(req_tuser);
         pid_ff    <= req_tdata[15:0];
         px_ff     <= req_tdata[47:16];
         py_ff     <= req_tdata[79:48];
         pz_ff     <= req_tdata[111:80];
         delta_ff  <= req_tdata[131:112];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_event_ff.z, rsp_event_ff.y, rsp_event_ff.x,
                        rsp_event_ff.partner};
   assign rsp_tuser  = rsp_event_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

   // The table never holds more entries than it has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count exceeds table depth");

   // No event is left pending once the block is ready again.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("pending event left behind at idle");

   // Stop and table-full beats carry a zero point.
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_STOP || rsp_tuser == EV_FULL)
      |-> rsp_tdata[111:16] == '0)
      else $error("stop or full event with nonzero point");

   // An empty table skips the walk.
   a_empty_skip: assert property (@(posedge clock) disable iff (reset)
      accept && count_ff == '0 |=> state_ff == ST_FINISH)
      else $error("walk started on an empty table");

   // A purge never removes more than the result cap.
   a_purge_cap: assert property (@(posedge clock) disable iff (reset)
      removed_ff <= REM_W'(MAX_RESULTS))
      else $error("purge removed more entries than allowed");

endmodule
